@@ src/dpcpa_pkg.sv @@
// Shared types, constants and the mode settings table of the charger power allocator.
package dpcpa_pkg;

   localparam int DEBOUNCE_LIMIT = 2;
   localparam int ADC_BITS       = 12;

   localparam int SPLIT_W    = 15;
   localparam int DELAY_W    = 4;
   localparam int NO_LOAD_W  = 14;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;
   localparam int VOUT_W     = 8;
   localparam int CUR_W      = 12;
   localparam int MODE_W     = 3;
   localparam int CODE_W     = 7;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 40;

   localparam logic [CUR_W-1:0] ADC_MASK = CUR_W'((64'd1 << ADC_BITS) - 64'd1);

   localparam logic [15:0] A2_LIMIT_LOW  = 16'd10416;
   localparam logic [15:0] A2_LIMIT_HIGH = 16'd651;
   localparam logic [SPLIT_W-1:0] MV_PER_UNIT = SPLIT_W'(6 * 16);

   localparam logic [SPLIT_W-1:0]   DEFAULT_SPLIT_MV = SPLIT_W'(16000);
   localparam logic [DELAY_W-1:0]   DEFAULT_DELAY    = DELAY_W'(10);
   localparam logic [NO_LOAD_W-1:0] DEFAULT_NO_LOAD  = NO_LOAD_W'(100);

   localparam logic [CSR_IDX_W-1:0] CSR_SPLIT_VOLTAGE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECHECK_DELAY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_LOAD_LIMIT = 2'd2;

   localparam logic [MODE_W-1:0] MODE_NONE    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_C1      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_C2      = 3'd2;
   localparam logic [MODE_W-1:0] MODE_A2      = 3'd3;
   localparam logic [MODE_W-1:0] MODE_C1_HIGH = 3'd4;
   localparam logic [MODE_W-1:0] MODE_C2_HIGH = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SHARED  = 3'd6;

   localparam logic [CODE_W-1:0] FIX_65W = CODE_W'(65000 / 20 / 50);
   localparam logic [CODE_W-1:0] FIX_20W = CODE_W'(20000 / 20 / 50);
   localparam logic [CODE_W-1:0] FIX_45W = CODE_W'(45000 / 20 / 50);
   localparam logic [CODE_W-1:0] FIX_30W = CODE_W'(30000 / 20 / 50);
   localparam logic [CODE_W-1:0] PPS_2A25 = CODE_W'(2250 / 50);
   localparam logic [CODE_W-1:0] PPS_5A   = CODE_W'(5000 / 50);
   localparam logic [CODE_W-1:0] PPS_4A   = CODE_W'(4000 / 50);
   localparam logic [CODE_W-1:0] PPS_3A   = CODE_W'(3000 / 50);

   typedef struct packed {
      logic [SPLIT_W-1:0]   split_voltage_mv;
      logic [DELAY_W-1:0]   recheck_delay_ticks;
      logic [NO_LOAD_W-1:0] no_load_limit;
   } cfg_type;

   typedef struct packed {
      logic              c1_status;
      logic              c2_status;
      logic              a2_status;
      logic [VOUT_W-1:0] vout2_high;
      logic [VOUT_W-1:0] vout1_high;
      logic [CUR_W-1:0]  a2_current;
      logic [CUR_W-1:0]  iout_chip1;
      logic [CUR_W-1:0]  iout_chip2;
   } item_type;

   typedef struct packed {
      logic [CODE_W-1:0] fix1;
      logic [CODE_W-1:0] pps1;
      logic              hi1;
      logic [CODE_W-1:0] fix2;
      logic [CODE_W-1:0] pps2;
      logic              hi2;
   } settings_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [2:0]        ports_present;
      settings_type      set;
      logic              settings_changed;
      logic              disconnect_chip1;
      logic              disconnect_chip2;
   } result_type;

   function automatic settings_type mode_settings(input logic [MODE_W-1:0] m);
      settings_type s;
      case (m)
         MODE_C1: begin
            s = '{FIX_65W, PPS_5A, 1'b1, FIX_20W, PPS_2A25, 1'b0};
         end
         MODE_C2, MODE_A2: begin
            s = '{FIX_20W, PPS_2A25, 1'b0, FIX_65W, PPS_5A, 1'b1};
         end
         MODE_C1_HIGH: begin
            s = '{FIX_45W, PPS_4A, 1'b1, FIX_20W, PPS_2A25, 1'b0};
         end
         MODE_C2_HIGH: begin
            s = '{FIX_20W, PPS_2A25, 1'b0, FIX_45W, PPS_4A, 1'b1};
         end
         MODE_SHARED: begin
            s = '{FIX_30W, PPS_3A, 1'b1, FIX_30W, PPS_3A, 1'b1};
         end
         default: begin
            s = '{FIX_65W, PPS_3A, 1'b1, FIX_65W, PPS_3A, 1'b1};
         end
      endcase
      return s;
   endfunction

endpackage

@@ src/dual_port_charger_power_allocator.sv @@
// Top level of the dual-port charger power allocator: registers, stream ports and CSRs.
//
//   Channel   Direction  Transaction
//   req_*     in         one tick: status bits and converter readings
//   rsp_*     out        one result per tick: mode, presence, settings, pulses
//   csr_*     in         register write, no read-back
//
// A tick transaction is held in an input register and its result is then loaded into
// the output register; a new transaction is taken every cycle unless the result
// stalls. All tick state updates as the result is loaded. Reset is synchronous and
// restores the register defaults and mode 0.
// A stalled result holds the output register; the input register then holds too.
module dual_port_charger_power_allocator #(
   parameter int DEBOUNCE_LIMIT = dpcpa_pkg::DEBOUNCE_LIMIT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // c1_status, c2_status, a2_status, vout2_high, vout1_high, a2_current,
   // iout_chip1, iout_chip2, zero pad
   input  logic [dpcpa_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // mode, ports_present, chip1_fixed_current, chip2_fixed_current,
   // chip1_pps_current, chip2_pps_current, chip1_high_pdo_on, chip2_high_pdo_on,
   // settings_changed, disconnect_chip1, disconnect_chip2, zero pad
   output logic [dpcpa_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_wr_en,
   input  logic [dpcpa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dpcpa_pkg::CSR_DATA_W-1:0]     csr_wr_data
);
   import dpcpa_pkg::*;

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   item_type   item_ff, item_in;
   logic       out_valid_ff;
   result_type result_ff, result_in;
   logic       advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign item_in.c1_status  = req_tdata[0];
   assign item_in.c2_status  = req_tdata[1];
   assign item_in.a2_status  = req_tdata[2];
   assign item_in.vout2_high = req_tdata[10:3];
   assign item_in.vout1_high = req_tdata[18:11];
   assign item_in.a2_current = req_tdata[30:19];
   assign item_in.iout_chip1 = req_tdata[42:31];
   assign item_in.iout_chip2 = req_tdata[54:43];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.split_voltage_mv    <= DEFAULT_SPLIT_MV;
         cfg_ff.recheck_delay_ticks <= DEFAULT_DELAY;
         cfg_ff.no_load_limit       <= DEFAULT_NO_LOAD;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SPLIT_VOLTAGE: begin
               cfg_ff.split_voltage_mv <= csr_wr_data[SPLIT_W-1:0];
            end
            CSR_RECHECK_DELAY: begin
               cfg_ff.recheck_delay_ticks <= csr_wr_data[DELAY_W-1:0];
            end
            CSR_NO_LOAD_LIMIT: begin
               cfg_ff.no_load_limit <= csr_wr_data[NO_LOAD_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= item_in;
      end
   end

   dpcpa_core #(
      .DEBOUNCE_LIMIT(DEBOUNCE_LIMIT)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (item_ff),
      .cfg   (cfg_ff),
      .result(result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0,
                        result_ff.disconnect_chip2,
                        result_ff.disconnect_chip1,
                        result_ff.settings_changed,
                        result_ff.set.hi2,
                        result_ff.set.hi1,
                        result_ff.set.pps2,
                        result_ff.set.pps1,
                        result_ff.set.fix2,
                        result_ff.set.fix1,
                        result_ff.ports_present,
                        result_ff.mode};

endmodule

@@ src/dpcpa_core.sv @@
// Per-tick state and logic: debounce, mode choice, settings and the no-load recheck.
module dpcpa_core #(
   parameter int DEBOUNCE_LIMIT = dpcpa_pkg::DEBOUNCE_LIMIT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  dpcpa_pkg::item_type   item,
   input  dpcpa_pkg::cfg_type    cfg,
   output dpcpa_pkg::result_type result
);
   import dpcpa_pkg::*;

   localparam int CntW = $clog2(DEBOUNCE_LIMIT + 1);
   localparam logic [CntW:0] DebLimit = (CntW + 1)'(DEBOUNCE_LIMIT);
   localparam settings_type ResetSettings = mode_settings(MODE_NONE);

   function automatic logic [CntW:0] debounce(input logic [CntW-1:0] cnt,
                                              input logic stored,
                                              input logic sample);
      logic [CntW:0] c;
      c = {1'b0, cnt} + 1'b1;
      if (stored != sample) begin
         if (c > DebLimit) begin
            return {1'b1, {CntW{1'b0}}};
         end
         return {1'b0, c[CntW-1:0]};
      end
      return '0;
   endfunction

   logic [2:0]          ports_ff, ports_in;
   logic [CntW-1:0]     c1_cnt_ff, c1_cnt_in;
   logic [CntW-1:0]     c2_cnt_ff, c2_cnt_in;
   logic [CntW-1:0]     a2_cnt_ff, a2_cnt_in;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [MODE_W-1:0]   applied_ff, applied_in;
   settings_type        set_ff, set_in;
   logic [CODE_W-1:0]   rec1_ff, rec1_in;
   logic [CODE_W-1:0]   rec2_ff, rec2_in;
   logic [1:0]          pending_ff, pending_in;
   logic [DELAY_W-1:0]  chk1_cnt_ff, chk1_cnt_in;
   logic [DELAY_W-1:0]  chk2_cnt_ff, chk2_cnt_in;

   logic                p_c1, p_c2, p_a2, new_a2;
   logic                c1_flip, c2_flip, a2_flip, changed, dis1, dis2;
   logic [CUR_W-1:0]    ia2, i1, i2;
   logic [VOUT_W-1:0]   a2_cur;
   logic [15:0]         a2_lim, a2_prod;
   logic                v1_split, v2_split;
   logic [DELAY_W:0]    chk1_sum, chk2_sum;
   logic [CUR_W+2:0]    i1_x5, i2_x5;

   always_comb begin
      ia2 = item.a2_current & ADC_MASK;
      i1  = item.iout_chip1 & ADC_MASK;
      i2  = item.iout_chip2 & ADC_MASK;

      if (ia2[CUR_W-1:8] != '0) begin
         a2_cur = ia2[11:4];
         a2_lim = A2_LIMIT_HIGH;
      end else begin
         a2_cur = ia2[7:0];
         a2_lim = A2_LIMIT_LOW;
      end
      a2_prod = 16'(a2_cur) * 16'(item.vout2_high);

      v1_split = (SPLIT_W'(item.vout1_high) * MV_PER_UNIT) > cfg.split_voltage_mv;
      v2_split = (SPLIT_W'(item.vout2_high) * MV_PER_UNIT) > cfg.split_voltage_mv;

      p_c1 = ports_ff[0];
      p_c2 = ports_ff[1];
      p_a2 = ports_ff[2];
      new_a2 = p_a2 ? item.a2_status : (a2_prod >= a2_lim);
      mode_in = mode_ff;

      {c1_flip, c1_cnt_in} = debounce(c1_cnt_ff, p_c1, item.c1_status);
      if (c1_flip) begin
         p_c1 = item.c1_status;
         if (p_c1) begin
            if (p_c2 || p_a2) begin
               mode_in = v2_split ? MODE_C2_HIGH : MODE_SHARED;
            end else begin
               mode_in = MODE_C1;
            end
         end else begin
            mode_in = (p_c2 || p_a2) ? MODE_C2 : MODE_NONE;
         end
      end

      {c2_flip, c2_cnt_in} = debounce(c2_cnt_ff, p_c2, item.c2_status);
      if (c2_flip) begin
         p_c2 = item.c2_status;
         if (!p_a2) begin
            if (p_c2) begin
               if (p_c1) begin
                  mode_in = v1_split ? MODE_C1_HIGH : MODE_SHARED;
               end else begin
                  mode_in = MODE_C2;
               end
            end else begin
               mode_in = p_c1 ? MODE_C1 : MODE_NONE;
            end
         end
      end

      {a2_flip, a2_cnt_in} = debounce(a2_cnt_ff, p_a2, new_a2);
      if (a2_flip) begin
         p_a2 = new_a2;
         if (!p_c2) begin
            if (p_a2) begin
               if (p_c1) begin
                  mode_in = v1_split ? MODE_C1_HIGH : MODE_SHARED;
               end else begin
                  mode_in = MODE_A2;
               end
            end else begin
               mode_in = p_c1 ? MODE_C1 : MODE_NONE;
            end
         end
      end

      ports_in = {p_a2, p_c2, p_c1};

      changed    = applied_ff != mode_in;
      applied_in = mode_in;
      set_in     = changed ? mode_settings(mode_in) : set_ff;
      rec1_in    = rec1_ff;
      rec2_in    = rec2_ff;
      pending_in = pending_ff;
      if (changed) begin
         if (rec1_ff != set_in.fix1) begin
            rec1_in = set_in.fix1;
            pending_in[0] = 1'b1;
         end
         if (rec2_ff != set_in.fix2) begin
            rec2_in = set_in.fix2;
            pending_in[1] = 1'b1;
         end
      end

      i1_x5 = {1'b0, i1, 2'b00} + (CUR_W + 3)'(i1);
      i2_x5 = {1'b0, i2, 2'b00} + (CUR_W + 3)'(i2);
      chk1_sum = {1'b0, chk1_cnt_ff} + 1'b1;
      chk2_sum = {1'b0, chk2_cnt_ff} + 1'b1;
      dis1 = 1'b0;
      dis2 = 1'b0;

      if (!pending_in[0]) begin
         chk1_cnt_in = '0;
      end else if (chk1_sum > {1'b0, cfg.recheck_delay_ticks}) begin
         chk1_cnt_in = '0;
         pending_in[0] = 1'b0;
         dis1 = i1_x5[CUR_W+2:1] < cfg.no_load_limit;
      end else begin
         chk1_cnt_in = chk1_sum[DELAY_W-1:0];
      end

      if (!pending_in[1]) begin
         chk2_cnt_in = '0;
      end else if (chk2_sum > {1'b0, cfg.recheck_delay_ticks}) begin
         chk2_cnt_in = '0;
         pending_in[1] = 1'b0;
         dis2 = i2_x5[CUR_W+2:1] < cfg.no_load_limit;
      end else begin
         chk2_cnt_in = chk2_sum[DELAY_W-1:0];
      end

      result.mode             = mode_in;
      result.ports_present    = ports_in;
      result.set              = set_in;
      result.settings_changed = changed;
      result.disconnect_chip1 = dis1;
      result.disconnect_chip2 = dis2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ports_ff    <= '0;
         c1_cnt_ff   <= '0;
         c2_cnt_ff   <= '0;
         a2_cnt_ff   <= '0;
         mode_ff     <= MODE_NONE;
         applied_ff  <= MODE_NONE;
         set_ff      <= ResetSettings;
         rec1_ff     <= '0;
         rec2_ff     <= '0;
         pending_ff  <= '0;
         chk1_cnt_ff <= '0;
         chk2_cnt_ff <= '0;
      end else if (step) begin
         ports_ff    <= ports_in;
         c1_cnt_ff   <= c1_cnt_in;
         c2_cnt_ff   <= c2_cnt_in;
         a2_cnt_ff   <= a2_cnt_in;
         mode_ff     <= mode_in;
         applied_ff  <= applied_in;
         set_ff      <= set_in;
         rec1_ff     <= rec1_in;
         rec2_ff     <= rec2_in;
         pending_ff  <= pending_in;
         chk1_cnt_ff <= chk1_cnt_in;
         chk2_cnt_ff <= chk2_cnt_in;
      end
   end

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the dual-port charger power allocator stream block.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dpcpa_pkg::*;

   localparam int unsigned STALL_LIMIT    = 4000;
   localparam int unsigned HOLD_OFF_TICKS = 300;
   localparam int unsigned A2_FULL_LIMIT  = 10416;
   localparam int unsigned A2_COARSE_LIM  = 651;
   localparam int unsigned MV_PER_LSB     = 96;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct packed {
      logic [CUR_W-1:0]  iout2;
      logic [CUR_W-1:0]  iout1;
      logic [CUR_W-1:0]  a2_cur;
      logic [VOUT_W-1:0] v1;
      logic [VOUT_W-1:0] v2;
      logic              a2_st;
      logic              c2_st;
      logic              c1_st;
   } tick_t;

   typedef struct packed {
      logic              dis2;
      logic              dis1;
      logic              changed;
      logic              hi2;
      logic              hi1;
      logic [CODE_W-1:0] pps2;
      logic [CODE_W-1:0] pps1;
      logic [CODE_W-1:0] fix2;
      logic [CODE_W-1:0] fix1;
      logic [2:0]        present;
      logic [MODE_W-1:0] mode;
   } outcome_t;

   localparam int OUTCOME_W = $bits(outcome_t);

   typedef struct {
      tick_t    stim;
      int       reps;
      bit       typed;
      outcome_t want;
   } dir_row_t;

   typedef struct {
      logic [CSR_DATA_W-1:0] split;
      logic [CSR_DATA_W-1:0] delay_word;
      logic [CSR_DATA_W-1:0] limit;
      int                    req_pct;
      int                    rsp_pct;
      int                    count;
      bit                    squeeze;
   } phase_t;

   localparam outcome_t IDLE_RESULT = '{mode: MODE_NONE, present: 3'b000,
      fix1: 7'd65, fix2: 7'd65, pps1: 7'd60, pps2: 7'd60, hi1: 1'b1, hi2: 1'b1,
      changed: 1'b0, dis1: 1'b0, dis2: 1'b0};
   localparam outcome_t C1_ATTACH_RESULT = '{mode: MODE_C1, present: 3'b001,
      fix1: 7'd65, fix2: 7'd20, pps1: 7'd100, pps2: 7'd45, hi1: 1'b1, hi2: 1'b0,
      changed: 1'b1, dis1: 1'b0, dis2: 1'b0};

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   dual_port_charger_power_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data)
   );

   // Allocator state as the block should hold it.
   logic [SPLIT_W-1:0]   split_mv;
   logic [DELAY_W-1:0]   recheck_delay;
   logic [NO_LOAD_W-1:0] no_load_lim;
   logic [2:0]           present_now;
   int                   deb_c1, deb_c2, deb_a2;
   logic [MODE_W-1:0]    mode_now, mode_applied;
   logic [CODE_W-1:0]    rec_fix1, rec_fix2;
   logic [1:0]           recheck_armed;
   int                   recheck_cnt1, recheck_cnt2;
   outcome_t             held;

   outcome_t    expected_results[$];
   int unsigned mismatch_count = 0;
   int unsigned stall_cycles   = 0;
   int          req_idle_pct   = 0;
   int          rsp_idle_pct   = 0;
   bit          hold_off_req   = 1'b0;
   int          episode_left   = 0;
   bit          ep_c1, ep_c2, ep_a2;
   dir_row_t    rows[$];
   phase_t      phases[6];

   function automatic void load_settings(logic [MODE_W-1:0] m);
      case (m)
         MODE_C1: begin
            held.fix1 = 65; held.pps1 = 100; held.hi1 = 1; held.fix2 = 20; held.pps2 = 45;
            held.hi2 = 0;
         end
         MODE_C2, MODE_A2: begin
            held.fix1 = 20; held.pps1 = 45; held.hi1 = 0; held.fix2 = 65; held.pps2 = 100;
            held.hi2 = 1;
         end
         MODE_C1_HIGH: begin
            held.fix1 = 45; held.pps1 = 80; held.hi1 = 1; held.fix2 = 20; held.pps2 = 45;
            held.hi2 = 0;
         end
         MODE_C2_HIGH: begin
            held.fix1 = 20; held.pps1 = 45; held.hi1 = 0; held.fix2 = 45; held.pps2 = 80;
            held.hi2 = 1;
         end
         MODE_SHARED: begin
            held.fix1 = 30; held.pps1 = 60; held.hi1 = 1; held.fix2 = 30; held.pps2 = 60;
            held.hi2 = 1;
         end
         default: begin
            held.fix1 = 65; held.pps1 = 60; held.hi1 = 1; held.fix2 = 65; held.pps2 = 60;
            held.hi2 = 1;
         end
      endcase
   endfunction

   function automatic void reset_allocator();
      split_mv      = DEFAULT_SPLIT_MV;
      recheck_delay = DEFAULT_DELAY;
      no_load_lim   = DEFAULT_NO_LOAD;
      present_now   = '0;
      deb_c1        = 0;
      deb_c2        = 0;
      deb_a2        = 0;
      mode_now      = MODE_NONE;
      mode_applied  = MODE_NONE;
      rec_fix1      = '0;
      rec_fix2      = '0;
      recheck_armed = '0;
      recheck_cnt1  = 0;
      recheck_cnt2  = 0;
      held          = '0;
      load_settings(MODE_NONE);
   endfunction

   function automatic void write_allocator_reg(logic [CSR_IDX_W-1:0] idx,
                                               logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_SPLIT_VOLTAGE: split_mv      = value[SPLIT_W-1:0];
         CSR_RECHECK_DELAY: recheck_delay = value[DELAY_W-1:0];
         CSR_NO_LOAD_LIMIT: no_load_lim   = value[NO_LOAD_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic bit debounce_flip(inout int cnt, input logic stored, input logic sample);
      if (stored != sample) begin
         cnt = cnt + 1;
         if (cnt > DEBOUNCE_LIMIT) begin
            cnt = 0;
            return 1'b1;
         end
         return 1'b0;
      end
      cnt = 0;
      return 1'b0;
   endfunction

   function automatic bit no_load_due(input int b, inout int cnt, input logic [CUR_W-1:0] raw);
      int unsigned scaled;
      if (!recheck_armed[b]) begin
         cnt = 0;
         return 1'b0;
      end
      cnt = cnt + 1;
      if (cnt > int'(recheck_delay)) begin
         cnt = 0;
         recheck_armed[b] = 1'b0;
         scaled = (int'(raw) * 5) >> 1;
         return scaled < 32'(no_load_lim);
      end
      return 1'b0;
   endfunction

   function automatic outcome_t charger_tick(tick_t t);
      outcome_t    r;
      logic        p_c1, p_c2, p_a2, a2_seen, chg;
      int unsigned cur, lim;
      p_c1 = present_now[0];
      p_c2 = present_now[1];
      p_a2 = present_now[2];
      chg  = 1'b0;
      if (!p_a2) begin
         cur = 32'(t.a2_cur);
         lim = A2_FULL_LIMIT;
         if ((cur >> 8) != 0) begin
            cur = cur >> 4;
            lim = A2_COARSE_LIM;
         end
         a2_seen = (cur * 32'(t.v2)) >= lim;
      end else begin
         a2_seen = t.a2_st;
      end
      if (debounce_flip(deb_c1, p_c1, t.c1_st)) begin
         p_c1 = t.c1_st;
         if (p_c1) begin
            if (p_c2 || p_a2)
               mode_now = (32'(t.v2) * MV_PER_LSB > 32'(split_mv)) ? MODE_C2_HIGH : MODE_SHARED;
            else
               mode_now = MODE_C1;
         end else begin
            mode_now = (p_c2 || p_a2) ? MODE_C2 : MODE_NONE;
         end
      end
      if (debounce_flip(deb_c2, p_c2, t.c2_st)) begin
         p_c2 = t.c2_st;
         if (!p_a2) begin
            if (p_c2) begin
               if (p_c1)
                  mode_now = (32'(t.v1) * MV_PER_LSB > 32'(split_mv)) ? MODE_C1_HIGH
                                                                       : MODE_SHARED;
               else
                  mode_now = MODE_C2;
            end else begin
               mode_now = p_c1 ? MODE_C1 : MODE_NONE;
            end
         end
      end
      if (debounce_flip(deb_a2, p_a2, a2_seen)) begin
         p_a2 = a2_seen;
         if (!p_c2) begin
            if (p_a2) begin
               if (p_c1)
                  mode_now = (32'(t.v1) * MV_PER_LSB > 32'(split_mv)) ? MODE_C1_HIGH
                                                                       : MODE_SHARED;
               else
                  mode_now = MODE_A2;
            end else begin
               mode_now = p_c1 ? MODE_C1 : MODE_NONE;
            end
         end
      end
      present_now = {p_a2, p_c2, p_c1};
      if (mode_applied != mode_now) begin
         mode_applied = mode_now;
         chg = 1'b1;
         load_settings(mode_now);
         if (rec_fix1 != held.fix1) begin
            rec_fix1 = held.fix1;
            recheck_armed[0] = 1'b1;
         end
         if (rec_fix2 != held.fix2) begin
            rec_fix2 = held.fix2;
            recheck_armed[1] = 1'b1;
         end
      end
      r         = held;
      r.mode    = mode_now;
      r.present = present_now;
      r.changed = chg;
      r.dis1    = no_load_due(0, recheck_cnt1, t.iout1);
      r.dis2    = no_load_due(1, recheck_cnt2, t.iout2);
      return r;
   endfunction

   function automatic tick_t tick(bit c1, bit c2, bit a2, int v2, int v1, int ia2, int i1,
                                  int i2);
      tick_t t;
      t.c1_st  = c1;
      t.c2_st  = c2;
      t.a2_st  = a2;
      t.v2     = VOUT_W'(v2);
      t.v1     = VOUT_W'(v1);
      t.a2_cur = CUR_W'(ia2);
      t.iout1  = CUR_W'(i1);
      t.iout2  = CUR_W'(i2);
      return t;
   endfunction

   function automatic logic [VOUT_W-1:0] pick_vout(int knee);
      int k;
      if ($urandom_range(0, 1) == 0)
         return VOUT_W'($urandom_range(0, 255));
      k = knee + int'($urandom_range(0, 4)) - 2;
      if (k < 0)
         k = 0;
      if (k > 255)
         k = 255;
      return VOUT_W'(k);
   endfunction

   function automatic logic [CUR_W-1:0] pick_current();
      int k;
      case ($urandom_range(0, 4))
         0, 1: return CUR_W'($urandom_range(0, 60));
         2: begin
            k = (int'(no_load_lim) * 2) / 5 + int'($urandom_range(0, 4)) - 2;
            if (k < 0)
               k = 0;
            if (k > 4095)
               k = 4095;
            return CUR_W'(k);
         end
         default: return CUR_W'($urandom_range(0, 4095));
      endcase
   endfunction

   // Mostly plug and unplug episodes long enough to pass the debounce, some glitches and noise.
   function automatic tick_t next_tick();
      tick_t       t;
      logic [63:0] raw;
      if ($urandom_range(0, 9) == 0) begin
         raw = {$urandom, $urandom};
         t   = raw[$bits(tick_t)-1:0];
         return t;
      end
      if (episode_left == 0) begin
         ep_c1 = 1'($urandom_range(0, 1));
         ep_c2 = 1'($urandom_range(0, 1));
         ep_a2 = 1'($urandom_range(0, 1));
         episode_left = ($urandom_range(0, 3) != 0) ? $urandom_range(3, 8) : $urandom_range(1, 2);
      end
      episode_left = episode_left - 1;
      t.c1_st = ep_c1;
      t.c2_st = ep_c2;
      t.a2_st = ep_a2;
      t.v1    = pick_vout(split_mv / MV_PER_LSB);
      t.v2    = pick_vout(split_mv / MV_PER_LSB);
      t.iout1 = pick_current();
      t.iout2 = pick_current();
      if (ep_a2) begin
         t.a2_cur = CUR_W'($urandom_range(256, 4095));
         if (t.v2 < 41)
            t.v2 = VOUT_W'($urandom_range(41, 255));
      end else if ($urandom_range(0, 4) == 0) begin
         case ($urandom_range(0, 6))
            0: begin t.a2_cur = 217;  t.v2 = 48; end
            1: begin t.a2_cur = 216;  t.v2 = 48; end
            2: begin t.a2_cur = 255;  t.v2 = 41; end
            3: begin t.a2_cur = 255;  t.v2 = 40; end
            4: begin t.a2_cur = 336;  t.v2 = 31; end
            5: begin t.a2_cur = 4095; t.v2 = 3;  end
            default: begin t.a2_cur = 256; t.v2 = 40; end
         endcase
      end else begin
         t.a2_cur = CUR_W'($urandom_range(0, 40));
      end
      return t;
   endfunction

   function automatic string field_diff(outcome_t e, outcome_t g);
      string s;
      s = "";
      if (e.mode !== g.mode)       s = {s, " mode"};
      if (e.present !== g.present) s = {s, " ports_present"};
      if (e.fix1 !== g.fix1)       s = {s, " chip1_fixed_current"};
      if (e.fix2 !== g.fix2)       s = {s, " chip2_fixed_current"};
      if (e.pps1 !== g.pps1)       s = {s, " chip1_pps_current"};
      if (e.pps2 !== g.pps2)       s = {s, " chip2_pps_current"};
      if (e.hi1 !== g.hi1)         s = {s, " chip1_high_pdo_on"};
      if (e.hi2 !== g.hi2)         s = {s, " chip2_high_pdo_on"};
      if (e.changed !== g.changed) s = {s, " settings_changed"};
      if (e.dis1 !== g.dis1)       s = {s, " disconnect_chip1"};
      if (e.dis2 !== g.dis2)       s = {s, " disconnect_chip2"};
      return s;
   endfunction

   function automatic void note_mismatch(string msg);
      if (mismatch_count < 10)
         $display("%s", msg);
      mismatch_count++;
   endfunction

   task automatic offer_tick(tick_t t, bit typed, outcome_t want);
      outcome_t e;
      if (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(0, 99) < req_idle_pct);
      end
      req_tdata  <= REQ_DATA_W'(t);
      req_tvalid <= 1'b1;
      do
         @(posedge clock);
      while (!req_tready);
      e = charger_tick(t);
      expected_results.push_back(typed ? want : e);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      write_allocator_reg(idx, value);
   endtask

   task automatic drain_results();
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_TICKS) @(posedge clock);
         end
         rsp_tready <= !(rsp_idle_pct != 0 && $urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      outcome_t got, exp;
      string    diff;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = outcome_t'(rsp_tdata[OUTCOME_W-1:0]);
         if (expected_results.size() == 0) begin
            note_mismatch($sformatf("unexpected result transaction %p", got));
         end else begin
            exp  = expected_results.pop_front();
            diff = field_diff(exp, got);
            if (diff != "")
               note_mismatch($sformatf("result mismatch in%s: expected %p, got %p",
                                       diff, exp, got));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      reset_allocator();
      rows.push_back('{tick(0, 0, 0, 0, 0, 0, 0, 0), 1, 1'b1, IDLE_RESULT});
      rows.push_back('{tick(1, 0, 0, 0, 0, 0, 0, 0), 2, 1'b1, IDLE_RESULT});
      rows.push_back('{tick(1, 0, 0, 0, 0, 0, 0, 0), 1, 1'b1, C1_ATTACH_RESULT});
      rows.push_back('{tick(1, 1, 1, 255, 255, 0, 4095, 4095), 3, 1'b0, '0});
      rows.push_back('{tick(0, 1, 0, 255, 0, 0, 0, 0), 3, 1'b0, '0});
      rows.push_back('{tick(1, 1, 0, 255, 0, 0, 0, 0), 3, 1'b0, '0});
      rows.push_back('{tick(1, 0, 0, 0, 0, 0, 0, 0), 3, 1'b0, '0});
      rows.push_back('{tick(1, 0, 0, 48, 0, 217, 0, 0), 3, 1'b0, '0});
      rows.push_back('{tick(0, 0, 1, 0, 0, 0, 0, 0), 3, 1'b0, '0});
      rows.push_back('{tick(0, 0, 0, 0, 0, 0, 0, 0), 3, 1'b0, '0});
      rows.push_back('{tick(0, 0, 0, 255, 0, 4095, 0, 0), 3, 1'b0, '0});

      phases[0] = '{15'd0,     15'h7FF0, 15'd0,     27, 56, 280, 1'b0};
      phases[1] = '{15'd32767, 15'd15,   15'd16383, 27, 56, 280, 1'b0};
      phases[2] = '{15'd9600,  15'd1,    15'd10237, 56, 27, 280, 1'b1};
      phases[3] = '{15'd24480, 15'd3,    15'd2000,  56, 27, 280, 1'b0};
      phases[4] = '{15'd16000, 15'd10,   15'd100,   0,  0,  280, 1'b0};
      phases[5] = '{15'd12000, 15'd6,    15'd700,   0,  0,  280, 1'b0};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_idle_pct = 27;
      rsp_idle_pct = 56;
      foreach (rows[i])
         repeat (rows[i].reps) offer_tick(rows[i].stim, rows[i].typed, rows[i].want);
      req_tvalid <= 1'b0;

      foreach (phases[p]) begin
         drain_results();
         write_reg(CSR_SPLIT_VOLTAGE, phases[p].split);
         write_reg(CSR_RECHECK_DELAY, phases[p].delay_word);
         write_reg(CSR_NO_LOAD_LIMIT, phases[p].limit);
         if (p == 0)
            write_reg(CSR_UNMAPPED, 15'h7FFF);
         csr_wr_en    <= 1'b0;
         req_idle_pct = phases[p].req_pct;
         rsp_idle_pct = phases[p].rsp_pct;
         if (phases[p].squeeze)
            hold_off_req = 1'b1;
         repeat (phases[p].count) offer_tick(next_tick(), 1'b0, '0);
         req_tvalid <= 1'b0;
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
